### design/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int MAX_SLOTS    = 1024;
  localparam int SLOT_W       = $clog2(MAX_SLOTS);
  localparam int CNT_W        = SLOT_W + 1;
  localparam int RESET_CAP    = 256;
  localparam int GROW_MIN     = 16;

  localparam logic [1:0] REQ_ACQUIRE = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    STAT_ACQUIRED = 3'd0,
    STAT_RELEASED = 3'd1,
    STAT_IGNORED  = 3'd2,
    STAT_FAILED   = 3'd3,
    STAT_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_GROW,
    S_REC_RD,
    S_REC_SET,
    S_REL_POS,
    S_REL_ENT,
    S_REL_LAST,
    S_REL_WR,
    S_ACQ_RD,
    S_ACQ_WR,
    S_CLR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    cap_req;
    logic    sweep_wr;
    logic    rd_victim;
    logic    set_victim;
    logic    rd_entry;
    logic    rd_last;
    logic    rel_commit;
    logic    grow_push;
    logic    acq_commit;
    logic    clr_step;
    logic    clr_end;
    logic    set_status;
    status_t status_code;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic free_empty;
    logic cap_full;
    logic live_empty;
    logic acq_ok;
    logic rel_ok;
    logic grow_done;
    logic clr_done;
    logic sweep_last;
    logic victim_mode;
    logic out_busy;
  } dp_stat_t;

endpackage

### design/spa_ram.sv
// ----------------------------------------------------------------------------
// spa_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/spa_ctrl.sv
// ----------------------------------------------------------------------------
// spa_ctrl
// Request sequencer: steps each request through the datapath.
// ----------------------------------------------------------------------------
module spa_ctrl
  import spa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       in_valid,
  input  logic [1:0] in_req,
  output logic       in_ready,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = STAT_IGNORED;
    in_ready        = 1'b0;
    case (state)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap_req = 1'b1;
          case (in_req)
            REQ_ACQUIRE: begin
              if (!stat.free_empty) state_next = S_ACQ_RD;
              else if (!stat.cap_full) state_next = S_GROW;
              else if (stat.live_empty) state_next = S_ACQ_RD;
              else state_next = S_REC_RD;
            end
            REQ_RELEASE: state_next = S_REL_POS;
            REQ_CLEAR:   state_next = S_CLR;
            default: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = STAT_IGNORED;
              state_next      = S_DONE;
            end
          endcase
        end
      end
      S_GROW: begin
        if (stat.grow_done) state_next = S_ACQ_RD;
        else cmd.grow_push = 1'b1;
      end
      S_REC_RD: begin
        cmd.rd_victim = 1'b1;
        state_next    = S_REC_SET;
      end
      S_REC_SET: begin
        cmd.set_victim = 1'b1;
        state_next     = S_REL_POS;
      end
      S_REL_POS: state_next = S_REL_ENT;
      S_REL_ENT: begin
        cmd.rd_entry = 1'b1;
        state_next   = S_REL_LAST;
      end
      S_REL_LAST: begin
        cmd.rd_last = 1'b1;
        state_next  = S_REL_WR;
      end
      S_REL_WR: begin
        cmd.rel_commit = 1'b1;
        if (stat.victim_mode) begin
          state_next = S_ACQ_RD;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = stat.rel_ok ? STAT_RELEASED : STAT_IGNORED;
          state_next      = S_DONE;
        end
      end
      S_ACQ_RD: begin
        if (stat.acq_ok) begin
          state_next = S_ACQ_WR;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_FAILED;
          state_next      = S_DONE;
        end
      end
      S_ACQ_WR: begin
        cmd.acq_commit  = 1'b1;
        cmd.set_status  = 1'b1;
        cmd.status_code = STAT_ACQUIRED;
        state_next      = S_DONE;
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) begin
          cmd.clr_end     = 1'b1;
          cmd.set_status  = 1'b1;
          cmd.status_code = STAT_CLEARED;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

### design/spa_dpath.sv
// ----------------------------------------------------------------------------
// spa_dpath
// Pool datapath: free stack, live list, slot positions, counters and the
// result register.
// ----------------------------------------------------------------------------
module spa_dpath
  import spa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic [SLOT_W-1:0] in_slot,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic              out_ready,
  output logic              out_valid,
  output status_t           out_status,
  output logic [SLOT_W-1:0] out_granted,
  output logic              out_rec,
  output logic [SLOT_W-1:0] out_rec_slot,
  output logic [CNT_W-1:0]  out_live
);

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_SLOTS);

  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  live_total;
  logic [CNT_W-1:0]  capacity_now;
  logic [CNT_W-1:0]  grow_end;
  logic [SLOT_W-1:0] sweep_idx;
  logic [CNT_W-1:0]  clr_idx;
  logic              clr_pend;
  logic [SLOT_W-1:0] rel_slot;
  logic [SLOT_W-1:0] pos_q;
  logic              match;
  logic              victim_mode;
  status_t           res_status;
  logic [SLOT_W-1:0] res_granted;
  logic              res_rec;
  logic [SLOT_W-1:0] res_rec_slot;

  logic              fs_we, ll_we, sp_we;
  logic [SLOT_W-1:0] fs_waddr, ll_waddr, sp_waddr, ll_raddr;
  logic [SLOT_W-1:0] fs_wdata, ll_wdata, sp_wdata;
  logic [SLOT_W-1:0] fs_rdata, ll_rdata, sp_rdata;

  logic [CNT_W-1:0]  cfg_cap;
  logic [CNT_W:0]    grow_add, grow_sum;
  logic [CNT_W-1:0]  grow_end_next;
  logic [CNT_W-1:0]  free_dec, live_dec;
  logic              can_push, rel_ok, clr_more;

  assign cfg_cap  = (cfg_wdata > MAX_C) ? MAX_C : cfg_wdata;
  assign grow_add = (capacity_now == '0) ? (CNT_W+1)'(GROW_MIN)
                                         : {2'b00, capacity_now[CNT_W-1:1]};
  assign grow_sum = {1'b0, capacity_now} + grow_add;
  assign grow_end_next = (grow_sum > {1'b0, MAX_C}) ? MAX_C : grow_sum[CNT_W-1:0];
  assign free_dec = free_count - CNT_W'(1);
  assign live_dec = live_total - CNT_W'(1);
  assign can_push = (free_count != MAX_C);
  assign rel_ok   = (live_total != '0) && ({1'b0, pos_q} < live_total) && match;
  assign clr_more = (clr_idx != live_total);

  assign stat.free_empty  = (free_count == '0);
  assign stat.cap_full    = (capacity_now >= MAX_C);
  assign stat.live_empty  = (live_total == '0);
  assign stat.acq_ok      = (free_count != '0) && (live_total < MAX_C);
  assign stat.rel_ok      = rel_ok;
  assign stat.grow_done   = (capacity_now == grow_end);
  assign stat.clr_done    = !clr_more && !clr_pend;
  assign stat.sweep_last  = (sweep_idx == SLOT_W'(MAX_SLOTS - 1));
  assign stat.victim_mode = victim_mode;
  assign stat.out_busy    = out_valid && !out_ready;

  always_comb begin
    fs_we    = 1'b0;
    fs_waddr = free_count[SLOT_W-1:0];
    fs_wdata = rel_slot;
    sp_we    = 1'b0;
    sp_waddr = ll_rdata;
    sp_wdata = pos_q;
    ll_we    = 1'b0;
    ll_waddr = pos_q;
    ll_wdata = ll_rdata;
    ll_raddr = clr_idx[SLOT_W-1:0];
    if (cmd.sweep_wr) begin
      fs_we    = 1'b1;
      fs_waddr = sweep_idx;
      fs_wdata = sweep_idx;
      sp_we    = 1'b1;
      sp_waddr = sweep_idx;
      sp_wdata = '0;
    end
    if (cmd.rel_commit && rel_ok) begin
      fs_we = can_push;
      sp_we = 1'b1;
      ll_we = 1'b1;
    end
    if (cmd.grow_push) begin
      fs_we    = can_push;
      fs_wdata = capacity_now[SLOT_W-1:0];
    end
    if (cmd.clr_step && clr_pend) begin
      fs_we    = can_push;
      fs_wdata = ll_rdata;
    end
    if (cmd.acq_commit) begin
      sp_we    = 1'b1;
      sp_waddr = fs_rdata;
      sp_wdata = live_total[SLOT_W-1:0];
      ll_we    = 1'b1;
      ll_waddr = live_total[SLOT_W-1:0];
      ll_wdata = fs_rdata;
    end
    if (cmd.rd_victim) ll_raddr = '0;
    if (cmd.rd_entry)  ll_raddr = sp_rdata;
    if (cmd.rd_last)   ll_raddr = live_dec[SLOT_W-1:0];
  end

  spa_ram #(.DEPTH(MAX_SLOTS), .WIDTH(SLOT_W)) u_free_stack (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(free_dec[SLOT_W-1:0]), .rdata(fs_rdata)
  );

  spa_ram #(.DEPTH(MAX_SLOTS), .WIDTH(SLOT_W)) u_live_list (
    .clk(clk), .we(ll_we), .waddr(ll_waddr), .wdata(ll_wdata),
    .raddr(ll_raddr), .rdata(ll_rdata)
  );

  spa_ram #(.DEPTH(MAX_SLOTS), .WIDTH(SLOT_W)) u_slot_pos (
    .clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
    .raddr(rel_slot), .rdata(sp_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= CNT_W'(RESET_CAP);
      live_total   <= '0;
      capacity_now <= CNT_W'(RESET_CAP);
      sweep_idx    <= '0;
      clr_idx      <= '0;
      clr_pend     <= 1'b0;
      victim_mode  <= 1'b0;
      out_valid    <= 1'b0;
    end else if (cfg_we) begin
      free_count   <= cfg_cap;
      live_total   <= '0;
      capacity_now <= cfg_cap;
      sweep_idx    <= '0;
    end else begin
      if (cmd.sweep_wr) sweep_idx <= sweep_idx + SLOT_W'(1);
      if (cmd.cap_req) begin
        victim_mode <= 1'b0;
        clr_idx     <= '0;
        clr_pend    <= 1'b0;
      end
      if (cmd.set_victim) victim_mode <= 1'b1;
      if (cmd.rel_commit && rel_ok) begin
        live_total <= live_dec;
        if (can_push) free_count <= free_count + CNT_W'(1);
      end
      if (cmd.grow_push) begin
        capacity_now <= capacity_now + CNT_W'(1);
        if (can_push) free_count <= free_count + CNT_W'(1);
      end
      if (cmd.acq_commit) begin
        free_count <= free_dec;
        live_total <= live_total + CNT_W'(1);
      end
      if (cmd.clr_step) begin
        if (clr_pend && can_push) free_count <= free_count + CNT_W'(1);
        clr_pend <= clr_more;
        if (clr_more) clr_idx <= clr_idx + CNT_W'(1);
      end
      if (cmd.clr_end) live_total <= '0;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_req) begin
      rel_slot     <= in_slot;
      grow_end     <= grow_end_next;
      res_granted  <= '0;
      res_rec      <= 1'b0;
      res_rec_slot <= '0;
    end
    if (cmd.set_victim) rel_slot <= ll_rdata;
    if (cmd.rd_entry) pos_q <= sp_rdata;
    if (cmd.rd_last) match <= (ll_rdata == rel_slot);
    if (cmd.rel_commit && rel_ok && victim_mode) begin
      res_rec      <= 1'b1;
      res_rec_slot <= rel_slot;
    end
    if (cmd.acq_commit) res_granted <= fs_rdata;
    if (cmd.set_status) res_status <= cmd.status_code;
    if (cmd.out_load) begin
      out_status   <= res_status;
      out_granted  <= res_granted;
      out_rec      <= res_rec;
      out_rec_slot <= res_rec_slot;
      out_live     <= live_total;
    end
  end

endmodule

### design/slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator
// Slot allocator with a LIFO free stack and a dense live list.
// ----------------------------------------------------------------------------
// One request is taken at a time; the answer goes to an output register, so
// the next request is accepted while the answer waits. An acquire reads the
// free stack before it writes; a release reads the slot's position, its
// live-list entry and the last live entry before it writes; an unknown
// request is answered as ignored; a clear reads and pushes one live-list entry
// per cycle. An acquire that grows the pool first pushes each new slot, and
// one that recycles live position 0 first releases that slot. A result still
// held in the output register delays the next load. The free-stack, live-list
// and position memories each read one word per cycle. After reset and after
// every write of initial_capacity the block rebuilds the free stack and clears
// the position table, with s_tready low.
// ----------------------------------------------------------------------------
module slot_pool_allocator
  import spa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // initial_capacity
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [9:0] slot_id
  input  logic [15:0] s_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [9:0] granted_slot, [10] recycled, [20:11] recycled_slot, [31:21] live_count
  output logic [31:0] m_tdata,
  // [2:0] status
  output logic [2:0]  m_tuser
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  status_t           out_status;
  logic [SLOT_W-1:0] out_granted;
  logic              out_rec;
  logic [SLOT_W-1:0] out_rec_slot;
  logic [CNT_W-1:0]  out_live;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spa_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_slot      (s_tdata[SLOT_W-1:0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_status   (out_status),
    .out_granted  (out_granted),
    .out_rec      (out_rec),
    .out_rec_slot (out_rec_slot),
    .out_live     (out_live)
  );

  assign m_tdata = {out_live, out_rec_slot, out_rec, out_granted};
  assign m_tuser = out_status;

endmodule

### bench/slot_pool_allocator_tb.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_tb
// Self-checking bench for the slot pool allocator. A directed table covers
// the corner cases: an empty pool, a capacity of one, growth from zero, and a
// capacity write above the limit. Random phases follow across several
// capacities. The fifth phase fills the pool to its limit with acquires alone,
// so that its last acquires recycle live slots, and the last phase keeps that
// capacity with no new write. The predicted answers are compared field by
// field with each word on the output stream. The sender runs in bursts and
// the receiver stalls on patterns of its own.
// ----------------------------------------------------------------------------
module slot_pool_allocator_tb
  import spa_pkg::*;
;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int END_SETTLE     = 64;
  localparam int KEEP_CAP       = -1;
  localparam int NUM_PHASES     = 6;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] granted;
    logic              recycled;
    logic [SLOT_W-1:0] recycled_slot;
    logic [CNT_W-1:0]  live;
  } answer_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [10:0] value;
    logic [1:0]  req;
    logic        has_exp;
    answer_t     exp;
  } dir_row_t;

  function automatic answer_t plain_ans(status_t st, int unsigned g, int unsigned l);
    answer_t a;
    a = '0;
    a.status = st;
    a.granted = SLOT_W'(g);
    a.live = CNT_W'(l);
    return a;
  endfunction

  localparam answer_t NO_ANS = '0;
  localparam int NUM_ROWS = 24;

  localparam dir_row_t DIR_ROWS [NUM_ROWS] = '{
    '{ROW_REQ, 11'd5,    REQ_RELEASE, 1'b1, plain_ans(STAT_IGNORED, 0, 0)},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 255, 1)},
    '{ROW_REQ, 11'd1023, REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 254, 2)},
    '{ROW_REQ, 11'd255,  REQ_RELEASE, 1'b1, plain_ans(STAT_RELEASED, 0, 1)},
    '{ROW_REQ, 11'd255,  REQ_RELEASE, 1'b1, plain_ans(STAT_IGNORED, 0, 1)},
    '{ROW_REQ, 11'd1023, REQ_UNKNOWN, 1'b1, plain_ans(STAT_IGNORED, 0, 1)},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 255, 2)},
    '{ROW_REQ, 11'd254,  REQ_RELEASE, 1'b0, NO_ANS},
    '{ROW_REQ, 11'd0,    REQ_CLEAR,   1'b1, plain_ans(STAT_CLEARED, 0, 0)},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b0, NO_ANS},
    '{ROW_CFG, 11'd1,    REQ_ACQUIRE, 1'b0, NO_ANS},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 0, 1)},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_FAILED, 0, 1)},
    '{ROW_REQ, 11'd0,    REQ_RELEASE, 1'b1, plain_ans(STAT_RELEASED, 0, 0)},
    '{ROW_CFG, 11'd0,    REQ_ACQUIRE, 1'b0, NO_ANS},
    '{ROW_REQ, 11'd0,    REQ_RELEASE, 1'b1, plain_ans(STAT_IGNORED, 0, 0)},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 15, 1)},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 14, 2)},
    '{ROW_REQ, 11'd15,   REQ_RELEASE, 1'b1, plain_ans(STAT_RELEASED, 0, 1)},
    '{ROW_CFG, 11'd2047, REQ_ACQUIRE, 1'b0, NO_ANS},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 1023, 1)},
    '{ROW_REQ, 11'd0,    REQ_CLEAR,   1'b1, plain_ans(STAT_CLEARED, 0, 0)},
    '{ROW_CFG, 11'd16,   REQ_ACQUIRE, 1'b0, NO_ANS},
    '{ROW_REQ, 11'd0,    REQ_ACQUIRE, 1'b1, plain_ans(STAT_ACQUIRED, 15, 1)}
  };

  localparam int PH_CAP   [NUM_PHASES] = '{0, 1, 16, 300, 1024, KEEP_CAP};
  localparam int PH_ITEMS [NUM_PHASES] = '{15, 10, 25, 15, 1030, 35};
  localparam int PH_ACQ   [NUM_PHASES] = '{60, 50, 75, 50, 100, 60};
  localparam int PH_REL   [NUM_PHASES] = '{25, 30, 15, 35, 0, 30};
  localparam int PH_CLR   [NUM_PHASES] = '{5, 5, 3, 5, 0, 3};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  int unsigned free_stack [MAX_SLOTS];
  int unsigned free_cnt;
  int unsigned live_list [MAX_SLOTS];
  int unsigned live_cnt;
  int unsigned slot_pos [MAX_SLOTS];
  int unsigned cap_now;

  answer_t pending_answers [$];
  int      mismatches = 0;
  int      burst_left = 0;
  int      idle_cycles = 0;
  int      stall_mode = 0;
  int      mode_left = 0;
  int      rx_cycle = 0;

  slot_pool_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic void pool_rebuild(int unsigned cap);
    if (cap > MAX_SLOTS) cap = MAX_SLOTS;
    cap_now = cap;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      free_stack[i] = i;
      live_list[i] = 0;
      slot_pos[i] = 0;
    end
    free_cnt = cap;
    live_cnt = 0;
  endfunction

  function automatic void push_free(int unsigned s);
    if (free_cnt < MAX_SLOTS) begin
      free_stack[free_cnt] = s;
      free_cnt++;
    end
  endfunction

  function automatic bit drop_live(int unsigned s);
    int unsigned pos;
    int unsigned last;
    if (live_cnt == 0 || s >= MAX_SLOTS) return 1'b0;
    pos = slot_pos[s];
    if (pos >= live_cnt || live_list[pos] != s) return 1'b0;
    last = live_list[live_cnt - 1];
    live_list[pos] = last;
    if (last < MAX_SLOTS) slot_pos[last] = pos;
    live_cnt--;
    push_free(s);
    return 1'b1;
  endfunction

  function automatic void pool_grow();
    int unsigned add;
    add = (cap_now > 0) ? cap_now / 2 : GROW_MIN;
    if (cap_now + add > MAX_SLOTS) add = MAX_SLOTS - cap_now;
    for (int unsigned i = 0; i < add; i++) push_free(cap_now + i);
    cap_now += add;
  endfunction

  function automatic answer_t pool_answer(logic [1:0] rq, logic [SLOT_W-1:0] sid);
    answer_t     a;
    int unsigned victim;
    int unsigned s;
    a = '0;
    a.status = STAT_IGNORED;
    case (rq)
      REQ_ACQUIRE: begin
        if (free_cnt == 0) begin
          if (cap_now < MAX_SLOTS) begin
            pool_grow();
          end else if (live_cnt > 0) begin
            victim = live_list[0];
            if (drop_live(victim)) begin
              a.recycled = 1'b1;
              a.recycled_slot = SLOT_W'(victim);
            end
          end
        end
        if (free_cnt == 0 || live_cnt >= MAX_SLOTS) begin
          a.status = STAT_FAILED;
        end else begin
          free_cnt--;
          s = free_stack[free_cnt];
          live_list[live_cnt] = s;
          if (s < MAX_SLOTS) slot_pos[s] = live_cnt;
          live_cnt++;
          a.granted = SLOT_W'(s);
          a.status = STAT_ACQUIRED;
        end
      end
      REQ_RELEASE: begin
        a.status = drop_live(32'(sid)) ? STAT_RELEASED : STAT_IGNORED;
      end
      REQ_CLEAR: begin
        for (int unsigned i = 0; i < live_cnt; i++) push_free(live_list[i]);
        live_cnt = 0;
        a.status = STAT_CLEARED;
      end
      default: a.status = STAT_IGNORED;
    endcase
    a.live = CNT_W'(live_cnt);
    return a;
  endfunction

  task automatic send_word(input logic [1:0] rq, input logic [SLOT_W-1:0] sid,
                           input logic has_exp, input answer_t typed_ans);
    answer_t ans;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser <= rq;
    s_tdata <= 16'(sid);
    do @(posedge clk); while (!s_tready);
    ans = pool_answer(rq, sid);
    pending_answers.insert(pending_answers.size(), has_exp ? typed_ans : ans);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input int unsigned v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= 11'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_rebuild(v & 11'h7FF);
  endtask

  task automatic check_field(input string fname, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, fname, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    answer_t want;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(3);
      mode_left = $urandom_range(16, 80);
    end
    mode_left--;
    rx_cycle++;
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(9) < 7);
      2: m_tready <= ($urandom_range(3) == 0);
      default: m_tready <= ((rx_cycle % 11) < 3);
    endcase
    if (m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        $display("%0t: word with nothing expected, expected none, got tuser %0d tdata %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("granted_slot", 32'(want.granted), 32'(m_tdata[9:0]));
        check_field("recycled", 32'(want.recycled), 32'(m_tdata[10]));
        check_field("recycled_slot", 32'(want.recycled_slot), 32'(m_tdata[20:11]));
        check_field("live_count", 32'(want.live), 32'(m_tdata[31:21]));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    dir_row_t          row;
    int                r;
    logic [1:0]        rq;
    logic [SLOT_W-1:0] sid;
    pool_rebuild(RESET_CAP);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIR_ROWS[i];
      if (row.kind == ROW_CFG) write_capacity(32'(row.value));
      else send_word(row.req, row.value[SLOT_W-1:0], row.has_exp, row.exp);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (PH_CAP[p] != KEEP_CAP) write_capacity(PH_CAP[p]);
      for (int n = 0; n < PH_ITEMS[p]; n++) begin
        r = $urandom_range(99);
        sid = SLOT_W'($urandom_range(MAX_SLOTS - 1));
        if (r < PH_ACQ[p]) begin
          rq = REQ_ACQUIRE;
        end else if (r < PH_ACQ[p] + PH_REL[p]) begin
          rq = REQ_RELEASE;
          if (live_cnt > 0) sid = SLOT_W'(live_list[$urandom_range(live_cnt - 1)]);
        end else if (r < PH_ACQ[p] + PH_REL[p] + PH_CLR[p]) begin
          rq = REQ_CLEAR;
        end else begin
          rq = $urandom_range(1) ? REQ_UNKNOWN : REQ_RELEASE;
        end
        send_word(rq, sid, 1'b0, NO_ANS);
      end
    end

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
design/spa_pkg.sv
design/spa_ram.sv
design/spa_ctrl.sv
design/spa_dpath.sv
design/slot_pool_allocator.sv
bench/slot_pool_allocator_tb.sv
